[rtl/ihs_pkg.sv]
// Shared types and constants for the indirect-key heapsort unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihs_pkg;

   localparam int IHS_MAX_ITEMS = 64;
   localparam int IDX_W         = 31;
   localparam int KEY_W         = 31;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
   } pair_type;

   typedef struct packed {
      logic [IDX_W-1:0] entry_index;
      logic [KEY_W-1:0] sort_key;
      logic             set_end;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] sorted_index;
      logic [KEY_W-1:0] sorted_key;
      logic             run_end;
      logic             overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_PRE_RD,
      ST_PRE_CMP,
      ST_PRE_WR2,
      ST_BUILD,
      ST_ROOT_RD,
      ST_ROOT_SWAP,
      ST_ROOT_WR2,
      ST_SORT,
      ST_SORT_RD,
      ST_SORT_TAIL,
      ST_SIFT_START,
      ST_SIFT_GRAB,
      ST_SIFT_CHILD,
      ST_SIFT_CMP,
      ST_EMIT
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/ihs_pair_ram.sv]
// Pair store: one write port, two registered read ports.
// Depends on ihs_pkg for the pair type.
`default_nettype none

module ihs_pair_ram
   import ihs_pkg::*;
#(
   parameter int DEPTH  = IHS_MAX_ITEMS,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire pair_type          wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output pair_type               rd_data_a,
   output pair_type               rd_data_b
);

   pair_type mem [DEPTH];
   pair_type rd_a_ff;
   pair_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[rtl/ihs_sequencer.sv]
// Load counter, heapsort sequencer around two key comparators, and
// result strobe. Drives the pair store ports; depends on ihs_pkg.
`default_nettype none

module ihs_sequencer
   import ihs_pkg::*;
#(
   parameter int MAX_ITEMS = IHS_MAX_ITEMS,
   parameter int ADDR_W    = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_payload,
   output logic                   rsp_strobe,
   output rsp_type                rsp_payload,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output pair_type               wr_data,
   output logic [ADDR_W-1:0]      rd_addr_a,
   output logic [ADDR_W-1:0]      rd_addr_b,
   input  wire pair_type          rd_data_a,
   input  wire pair_type          rd_data_b
);

   localparam int POS_W = $clog2(MAX_ITEMS + 1);

   seq_state_type    state_ff, state_in;
   seq_state_type    ret_ff, ret_in;
   logic [POS_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] n_ff, n_in;
   logic [POS_W-1:0] m_ff, m_in;
   logic             even_ff, even_in;
   logic [POS_W-1:0] i_ff, i_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] size_ff, size_in;
   logic [POS_W-1:0] k_ff, k_in;
   pair_type         moving_ff, moving_in;
   pair_type         top_ff, top_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_end_ff, rsp_end_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             accept;
   logic             full;
   logic [POS_W-1:0] n_new;
   logic             even_new;
   logic [POS_W-1:0] m_half;
   logic [POS_W-1:0] i_dec;
   logic [POS_W-1:0] k_inc;
   logic             last_emit;
   logic [POS_W:0]   left;
   logic [POS_W:0]   right;
   logic             leaf_stop;
   logic             b_wins;
   pair_type         pick;
   logic [POS_W:0]   pick_pos;
   logic             sift_stop;
   pair_type         load_pair;

   assign busy      = (state_ff != ST_LOAD);
   assign accept    = start && !busy;
   assign full      = (count_ff >= POS_W'(MAX_ITEMS));
   assign n_new     = full ? count_ff : count_ff + 1'b1;
   assign even_new  = !n_new[0];
   assign m_half    = m_ff >> 1;
   assign i_dec     = i_ff - 1'b1;
   assign k_inc     = k_ff + 1'b1;
   assign last_emit = (k_inc == n_ff);

   // key comparators: one compare, also used by the lone-leaf check, picks
   // the larger child, one decides whether the moving pair sinks further
   assign left      = {pos_ff, 1'b1};
   assign right     = left + 1'b1;
   assign leaf_stop = (left >= {1'b0, size_ff});
   assign b_wins    = (rd_data_a.key < rd_data_b.key);
   assign pick      = b_wins ? rd_data_b : rd_data_a;
   assign pick_pos  = b_wins ? right : left;
   assign sift_stop = (pick.key <= moving_ff.key);

   assign load_pair.idx = req_payload.entry_index;
   assign load_pair.key = req_payload.sort_key;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_payload.set_end) begin
               state_in = even_new ? ST_PRE_RD : ST_BUILD;
            end
         end
         ST_PRE_RD:     state_in = ST_PRE_CMP;
         ST_PRE_CMP:    state_in = b_wins ? ST_PRE_WR2 : ST_BUILD;
         ST_PRE_WR2:    state_in = ST_BUILD;
         ST_BUILD: begin
            if (i_ff != '0) begin
               state_in = ST_SIFT_START;
            end else begin
               state_in = even_ff ? ST_ROOT_RD : ST_SORT;
            end
         end
         ST_ROOT_RD:    state_in = ST_ROOT_SWAP;
         ST_ROOT_SWAP:  state_in = ST_ROOT_WR2;
         ST_ROOT_WR2:   state_in = ST_SIFT_START;
         ST_SORT:       state_in = (i_ff > POS_W'(1)) ? ST_SORT_RD : ST_EMIT;
         ST_SORT_RD:    state_in = ST_SIFT_START;
         ST_SORT_TAIL:  state_in = ST_SORT;
         ST_SIFT_START: state_in = ST_SIFT_GRAB;
         ST_SIFT_GRAB:  state_in = ST_SIFT_CHILD;
         ST_SIFT_CHILD: state_in = leaf_stop ? ret_ff : ST_SIFT_CMP;
         ST_SIFT_CMP:   state_in = sift_stop ? ret_ff : ST_SIFT_CHILD;
         ST_EMIT:       state_in = last_emit ? ST_LOAD : ST_EMIT;
         default:       state_in = ST_LOAD;
      endcase
   end

   // datapath registers
   always_comb begin
      ret_in       = ret_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      even_in      = even_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      moving_in    = moving_ff;
      top_in       = top_ff;
      rsp_valid_in = 1'b0;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = n_new;
               ovf_in   = ovf_ff | full;
               if (req_payload.set_end) begin
                  n_in    = n_new;
                  even_in = even_new;
                  m_in    = even_new ? n_new - 1'b1 : n_new;
                  i_in    = (even_new ? n_new - 1'b1 : n_new) >> 1;
                  k_in    = '0;
               end
            end
         end
         ST_PRE_CMP: begin
            moving_in = rd_data_a;
         end
         ST_BUILD: begin
            if (i_ff != '0) begin
               pos_in  = i_dec;
               size_in = m_ff;
               i_in    = i_dec;
               ret_in  = ST_BUILD;
            end else if (!even_ff) begin
               i_in = m_ff;
            end
         end
         ST_ROOT_SWAP: begin
            moving_in = rd_data_a;
         end
         ST_ROOT_WR2: begin
            pos_in  = '0;
            size_in = m_ff;
            i_in    = m_ff;
            ret_in  = ST_SORT;
         end
         ST_SORT_RD: begin
            top_in  = rd_data_a;
            pos_in  = '0;
            size_in = i_dec;
            ret_in  = ST_SORT_TAIL;
         end
         ST_SORT_TAIL: begin
            i_in = i_dec;
         end
         ST_SIFT_GRAB: begin
            moving_in = rd_data_a;
         end
         ST_SIFT_CMP: begin
            if (!sift_stop) begin
               pos_in = pick_pos[POS_W-1:0];
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_end_in   = last_emit;
            rsp_ovf_in   = ovf_ff;
            k_in         = k_inc;
            if (last_emit) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // pair store port control
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = moving_ff;
      rd_addr_a = '0;
      rd_addr_b = '0;
      unique case (state_ff)
         ST_LOAD: begin
            wr_en   = accept && !full;
            wr_addr = count_ff[ADDR_W-1:0];
            wr_data = load_pair;
         end
         ST_PRE_RD: begin
            rd_addr_a = m_half[ADDR_W-1:0];
            rd_addr_b = m_ff[ADDR_W-1:0];
         end
         ST_PRE_CMP: begin
            wr_en   = b_wins;
            wr_addr = m_half[ADDR_W-1:0];
            wr_data = rd_data_b;
         end
         ST_PRE_WR2, ST_ROOT_WR2: begin
            wr_en   = 1'b1;
            wr_addr = m_ff[ADDR_W-1:0];
         end
         ST_ROOT_RD: begin
            rd_addr_b = m_ff[ADDR_W-1:0];
         end
         ST_ROOT_SWAP, ST_SORT_RD: begin
            wr_en   = 1'b1;
            wr_data = rd_data_b;
         end
         ST_SORT: begin
            rd_addr_b = i_dec[ADDR_W-1:0];
         end
         ST_SORT_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = i_dec[ADDR_W-1:0];
            wr_data = top_ff;
         end
         ST_SIFT_START: begin
            rd_addr_a = pos_ff[ADDR_W-1:0];
         end
         ST_SIFT_CHILD: begin
            // a right child at the heap size still reads the stale copy there
            wr_en     = leaf_stop;
            wr_addr   = pos_ff[ADDR_W-1:0];
            rd_addr_a = left[ADDR_W-1:0];
            rd_addr_b = right[ADDR_W-1:0];
         end
         ST_SIFT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[ADDR_W-1:0];
            wr_data = sift_stop ? moving_ff : pick;
         end
         ST_EMIT: begin
            rd_addr_a = k_ff[ADDR_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      n_ff       <= n_in;
      m_ff       <= m_in;
      even_ff    <= even_in;
      i_ff       <= i_in;
      pos_ff     <= pos_in;
      size_ff    <= size_in;
      k_ff       <= k_in;
      moving_ff  <= moving_in;
      top_ff     <= top_in;
      rsp_end_ff <= rsp_end_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_strobe               = rsp_valid_ff;
   assign rsp_payload.sorted_index = rd_data_a.idx;
   assign rsp_payload.sorted_key   = rd_data_a.key;
   assign rsp_payload.run_end      = rsp_end_ff;
   assign rsp_payload.overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

[rtl/indirect_key_heapsort_unit.sv]
// Indirect-key heapsort unit. A beat is loaded on each start while busy is low;
// the beat with set_end starts an in-place heapsort of the N stored pairs, run
// on two key comparators and the store's one write port. Sorted beats then
// leave one per cycle. busy stays high from the set_end beat on and drops in
// the cycle that the last result is on the ports; results cannot be stalled.
// Reset clears the count, overflow flag and sequencer; store contents are
// undefined until loaded.
`default_nettype none

module indirect_key_heapsort_unit
   import ihs_pkg::*;
#(
   parameter int MAX_ITEMS = IHS_MAX_ITEMS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_payload,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   pair_type          wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [ADDR_W-1:0] rd_addr_b;
   pair_type          rd_data_a;
   pair_type          rd_data_b;

   ihs_pair_ram #(
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   ihs_sequencer #(
      .MAX_ITEMS (MAX_ITEMS),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr_a   (rd_addr_a),
      .rd_addr_b   (rd_addr_b),
      .rd_data_a   (rd_data_a),
      .rd_data_b   (rd_data_b)
   );

endmodule

`default_nettype wire

[tb/sv/ihs_sort_watch.sv]
// Watches the beat and result channels of the heapsort unit, predicts each sorted run
// and compares it field by field. Depends on ihs_pkg for the payload types.
`timescale 1ns / 100ps

module ihs_sort_watch
   import ihs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_payload,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_payload,
   output int           mismatches,
   output int           outstanding
);

   pair_type pair_slots [0:63];
   int       stored_count;
   bit       surplus_seen;
   rsp_type  expected_run [$];

   function automatic void sift_slot(int pos, int size);
      pair_type         moving;
      int               left;
      int               pick;
      logic [KEY_W-1:0] pick_key;
      logic [KEY_W-1:0] right_key;
      moving = pair_slots[pos & 63];
      while (1) begin
         left = 2 * pos + 1;
         if (left >= size)
            break;
         pick      = left;
         pick_key  = pair_slots[left & 63].key;
         // right child may sit at index == size, where the sifted copy stands
         right_key = pair_slots[(left + 1) & 63].key;
         if (pick_key < right_key) begin
            pick     = left + 1;
            pick_key = right_key;
         end
         if (pick_key <= moving.key)
            break;
         pair_slots[pos & 63] = pair_slots[pick & 63];
         pos = pick;
      end
      pair_slots[pos & 63] = moving;
   endfunction

   function automatic void heapsort_slots(int n);
      int       m;
      int       last;
      bit       even_n;
      pair_type held;
      m      = n;
      even_n = (n % 2) == 0;
      if (even_n) begin
         // lone leaf checked against its parent before the heap is built
         m--;
         if (pair_slots[m / 2].key < pair_slots[m].key) begin
            held               = pair_slots[m];
            pair_slots[m]      = pair_slots[m / 2];
            pair_slots[m / 2]  = held;
         end
      end
      for (int i = m / 2; i > 0; i--)
         sift_slot(i - 1, m);
      if (even_n) begin
         held          = pair_slots[0];
         pair_slots[0] = pair_slots[m];
         pair_slots[m] = held;
         sift_slot(0, m);
      end
      for (int i = m; i > 1; i--) begin
         last             = i - 1;
         held             = pair_slots[0];
         pair_slots[0]    = pair_slots[last];
         sift_slot(0, last);
         pair_slots[last] = held;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored_count <= 0;
         surplus_seen <= 1'b0;
         mismatches   <= 0;
         outstanding  <= 0;
         expected_run.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_run.size() == 0) begin
               $display("%0t: result with nothing expected: actual %p", $time, rsp_payload);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_run.pop_front();
               if (rsp_payload.sorted_index !== want.sorted_index ||
                   rsp_payload.sorted_key !== want.sorted_key ||
                   rsp_payload.run_end !== want.run_end ||
                   rsp_payload.overflow !== want.overflow) begin
                  $display("%0t: result mismatch: expected %p actual %p",
                           $time, want, rsp_payload);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (start && !busy) begin
            int  count_now;
            bit  surplus_now;
            count_now   = stored_count;
            surplus_now = surplus_seen;
            if (count_now < IHS_MAX_ITEMS) begin
               pair_slots[count_now].idx = req_payload.entry_index;
               pair_slots[count_now].key = req_payload.sort_key;
               count_now++;
            end else begin
               surplus_now = 1'b1;
            end
            if (req_payload.set_end) begin
               if (count_now > 0)
                  heapsort_slots(count_now);
               for (int k = 0; k < count_now; k++) begin
                  want.sorted_index = pair_slots[k].idx;
                  want.sorted_key   = pair_slots[k].key;
                  want.run_end      = (k + 1 == count_now);
                  want.overflow     = surplus_now;
                  expected_run.push_back(want);
               end
               count_now   = 0;
               surplus_now = 1'b0;
            end
            stored_count <= count_now;
            surplus_seen <= surplus_now;
         end
         outstanding <= expected_run.size();
      end
   end

endmodule

[tb/sv/testbench.sv]
// Top of the heapsort unit testbench: clock, reset, beat stimulus and verdict.
// Depends on ihs_pkg, indirect_key_heapsort_unit and ihs_sort_watch.
`timescale 1ns / 100ps

module testbench;
   import ihs_pkg::*;

   localparam logic [30:0] ALL_ONES = 31'h7FFFFFFF;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    start       = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      mismatches;
   int      outstanding;
   bit      no_gaps;
   int      beats_sent;

   always #1 clock = ~clock;

   indirect_key_heapsort_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   ihs_sort_watch u_watch (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Called right after the previous beat's accepting edge.
   task automatic send_entry(input logic [30:0] idx, input logic [30:0] key,
                             input logic last);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55)
         gap = 0;
      else if (roll < 90)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= '{entry_index: idx, sort_key: key, set_end: last};
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   initial begin
      int set_no;
      int set_size;
      int key_mode;
      logic [30:0] key;
      beats_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, equal keys, even and odd sizes
      no_gaps = 1'b0;
      send_entry(ALL_ONES, ALL_ONES, 1'b1);
      send_entry('0, '0, 1'b1);
      send_entry(31'd5, 31'd100, 1'b0);
      send_entry(31'd9, 31'd100, 1'b1);
      for (int i = 0; i < 3; i++)
         send_entry(31'(i), (i == 2) ? 31'd3 : 31'd7, i == 2);
      for (int i = 0; i < 4; i++)
         send_entry(i[0] ? 31'h55555555 : 31'h2AAAAAAA, i[0] ? '0 : ALL_ONES, i == 3);
      for (int i = 0; i < 6; i++)
         send_entry(31'(i), 31'h2AAAAAAA, i == 5);
      for (int i = 0; i < 5; i++)
         send_entry(31'(100 + i), 31'(50 - i), i == 4);

      // hold off until every result of the directed sets is back
      drain_results();

      set_no = 0;
      while (set_no <= 5 || beats_sent < 150) begin
         // full store followed by surplus beats, the last one carrying set_end
         if (set_no == 3)
            set_size = IHS_MAX_ITEMS + 2;
         else if ($urandom_range(0, 7) == 0)
            set_size = $urandom_range(11, 40);
         else
            set_size = $urandom_range(1, 10);
         key_mode = $urandom_range(0, 2);
         no_gaps  = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < set_size; i++) begin
            case (key_mode)
               0:       key = 31'($urandom());
               1:       key = 31'($urandom_range(0, 7));
               default: key = ALL_ONES - 31'($urandom_range(0, 3));
            endcase
            send_entry(31'($urandom()), key, i == set_size - 1);
         end
         set_no++;
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
rtl/ihs_pkg.sv
rtl/ihs_pair_ram.sv
rtl/ihs_sequencer.sv
rtl/indirect_key_heapsort_unit.sv
tb/sv/ihs_sort_watch.sv
tb/sv/testbench.sv
